// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the table's modules.
// Each check samples on clk and is held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_AT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/uk_pkg.sv =====
package uk_pkg;

	// Table geometry
	localparam int ENTRIES     = 16;
	localparam int MAX_RESULTS = 16;
	localparam int LIST_N      = (ENTRIES < MAX_RESULTS) ? ENTRIES : MAX_RESULTS;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int CNT_W       = $clog2(ENTRIES + 1);

	// Field widths
	localparam int MODE_W   = 2;
	localparam int KEY_W    = 64;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
	localparam logic [MODE_W-1:0] MODE_LIST   = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd6;
	localparam logic [STATUS_W-1:0] ST_LIST      = 3'd7;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [KEY_W-1:0]    entry_key;
		logic                last;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;    // latch request and match results
		logic exec;       // apply a single-result request
		logic list_step;  // emit one list entry
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;      // table holds no entries
		logic list_end;   // current list entry is the final one
	} ctl_sts_t;

endpackage

// ===== hdl/uk_ctrl.sv =====
`include "assert_macros.svh"

module uk_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [uk_pkg::MODE_W-1:0]   mode,
	input  uk_pkg::ctl_sts_t            sts,
	output uk_pkg::ctl_cmd_t            cmd,
	output logic                        busy
);
	import uk_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Decode next state and commands
	always_comb begin
		state_d       = state_q;
		cmd.capture   = 1'b0;
		cmd.exec      = 1'b0;
		cmd.list_step = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					if (mode == MODE_LIST && !sts.empty)
						state_d = S_LIST;
					else
						state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			S_LIST: begin
				cmd.list_step = 1'b1;
				if (sts.list_end)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	`ASSERT_AT_CLK(a_exec_one_cycle, (state_q == S_EXEC) |=> (state_q == S_IDLE), "exec lasted more than one cycle")
	`ASSERT_AT_CLK(a_accept_busy, accept |=> busy, "accepted item did not raise busy")
	`ASSERT_NEVER(a_list_from_empty, accept && mode == MODE_LIST && sts.empty && state_d == S_LIST, "list walk started on empty table")

endmodule

// ===== hdl/uk_dp.sv =====
`include "assert_macros.svh"

module uk_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  uk_pkg::req_t       req,
	input  uk_pkg::ctl_cmd_t   cmd,
	output uk_pkg::ctl_sts_t   sts,
	output logic               done,
	output uk_pkg::rsp_t       rsp
);
	import uk_pkg::*;

	// Key slots and occupancy
	logic [KEY_W-1:0]  keys_q [ENTRIES];
	logic [CNT_W-1:0]  count_q;

	// Latched request and match
	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic              hit_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  idx_q;

	logic [ENTRIES-1:0] match;
	logic               hit_d;
	logic [IDX_W-1:0]   pos_d;
	logic [CNT_W-1:0]   list_lim;
	logic [CNT_W-1:0]   idx_next;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   rd_addr;
	logic [KEY_W-1:0]   rd_data;
	logic               full;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [KEY_W-1:0]   wr_data;
	logic [CNT_W-1:0]   count_d;
	rsp_t               rsp_d;

	// Compare the incoming key against every occupied slot
	always_comb begin
		for (int i = 0; i < ENTRIES; i++)
			match[i] = (keys_q[i] == req.key) && (CNT_W'(i) < count_q);
	end

	// Pick the lowest matching slot
	always_comb begin
		pos_d = '0;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (match[i])
				pos_d = IDX_W'(i);
	end
	assign hit_d = |match;

	assign full     = (count_q == CNT_W'(ENTRIES));
	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign list_lim = (count_q > CNT_W'(LIST_N)) ? CNT_W'(LIST_N) : count_q;
	assign idx_next = CNT_W'(idx_q) + CNT_W'(1);

	assign sts.empty    = (count_q == '0);
	assign sts.list_end = (idx_next == list_lim);

	// Single read port: list walk or last entry for delete
	assign rd_addr = cmd.list_step ? idx_q : last_idx;
	assign rd_data = keys_q[rd_addr];

	// Work out the update and the result
	always_comb begin
		wr_en           = 1'b0;
		wr_addr         = pos_q;
		wr_data         = rd_data;
		count_d         = count_q;
		rsp_d.status    = ST_NOT_FOUND;
		rsp_d.slot      = '0;
		rsp_d.entry_key = '0;
		rsp_d.last      = 1'b1;
		if (cmd.list_step) begin
			rsp_d.status    = ST_LIST;
			rsp_d.slot      = SLOT_W'(idx_q);
			rsp_d.entry_key = rd_data;
			rsp_d.last      = sts.list_end;
		end else begin
			unique case (mode_q)
				MODE_CREATE: begin
					if (hit_q) begin
						rsp_d.status = ST_EXISTS;
						rsp_d.slot   = SLOT_W'(pos_q);
					end else if (full) begin
						rsp_d.status = ST_FULL;
					end else begin
						wr_en        = cmd.exec;
						wr_addr      = IDX_W'(count_q);
						wr_data      = key_q;
						count_d      = count_q + CNT_W'(1);
						rsp_d.status = ST_ADDED;
						rsp_d.slot   = SLOT_W'(count_q);
					end
				end
				MODE_DELETE: begin
					if (hit_q) begin
						wr_en        = cmd.exec;
						count_d      = count_q - CNT_W'(1);
						rsp_d.status = ST_DELETED;
						rsp_d.slot   = SLOT_W'(pos_q);
					end
				end
				MODE_SEARCH: begin
					if (hit_q) begin
						rsp_d.status = ST_FOUND;
						rsp_d.slot   = SLOT_W'(pos_q);
					end
				end
				MODE_LIST: begin
					rsp_d.status = ST_EMPTY;
				end
				default: begin
					rsp_d.status = ST_NOT_FOUND;
				end
			endcase
		end
	end

	// Write key slots
	always_ff @(posedge clk) begin
		if (wr_en)
			keys_q[wr_addr] <= wr_data;
	end

	// Hold the request and its match
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= req.mode;
			key_q  <= req.key;
			hit_q  <= hit_d;
			pos_q  <= pos_d;
		end
	end

	// Advance the list index
	always_ff @(posedge clk) begin
		if (cmd.capture)
			idx_q <= '0;
		else if (cmd.list_step)
			idx_q <= IDX_W'(idx_next);
	end

	// Update occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd.exec)
			count_q <= count_d;
	end

	// Register the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= cmd.exec || cmd.list_step;
	end

	// Register the result item
	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.list_step)
			rsp <= rsp_d;
	end

	`ASSERT_AT_CLK(a_count_bound, count_q <= CNT_W'(ENTRIES), "entry count beyond table size")
	`ASSERT_NEVER(a_list_empty, cmd.list_step && count_q == '0, "list step on empty table")
	`ASSERT_AT_CLK(a_list_exec_empty, (cmd.exec && mode_q == MODE_LIST) |-> (count_q == '0), "list handled as single result on filled table")

endmodule

// ===== hdl/unique_key_table.sv =====
// Table of up to 16 unique 64-bit keys. Pulse start while busy is low to
// issue a request: create, delete, search or list. Each result item is shown
// on rsp for exactly one cycle with done high and cannot be held off, so the
// receiver must take it then. Create, delete and search each give a single
// result, which appears in the first cycle that busy is low again; all slots
// are compared in parallel in the accept cycle. List walks the stored entries
// (at most 16) through the single key read port, one result item each, and
// marks the final one with last; an empty table gives one empty result.
module unique_key_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  uk_pkg::req_t  req,
	output logic          done,
	output uk_pkg::rsp_t  rsp
);
	import uk_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	uk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (req.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	uk_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	import uk_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int POOL_N      = 24;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// Predicted table contents and pending results
	logic [KEY_W-1:0] tbl_keys [ENTRIES];
	int               tbl_count;
	rsp_t             due_rsp [$];
	logic [KEY_W-1:0] key_pool [POOL_N];

	int n_items;
	int n_results;
	int n_errors;
	int n_full_hits;
	int n_full_lists;
	int quiet;

	unique_key_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one request to the predicted table and queue the results it gives
	function automatic void apply_request(req_t r);
		rsp_t o;
		int   hit;
		int   n;
		int   i;
		hit = -1;
		for (i = 0; i < tbl_count; i++)
			if (hit < 0 && tbl_keys[i] == r.key)
				hit = i;
		o = '0;
		o.last = 1'b1;
		case (r.mode)
			MODE_CREATE: begin
				if (hit >= 0) begin
					o.status = ST_EXISTS;
					o.slot   = SLOT_W'(hit);
				end else if (tbl_count >= ENTRIES) begin
					o.status = ST_FULL;
					n_full_hits++;
				end else begin
					tbl_keys[tbl_count] = r.key;
					o.status = ST_ADDED;
					o.slot   = SLOT_W'(tbl_count);
					tbl_count++;
				end
				due_rsp.push_back(o);
			end
			MODE_DELETE: begin
				if (hit >= 0) begin
					tbl_keys[hit] = tbl_keys[tbl_count-1];
					tbl_count--;
					o.status = ST_DELETED;
					o.slot   = SLOT_W'(hit);
				end else begin
					o.status = ST_NOT_FOUND;
				end
				due_rsp.push_back(o);
			end
			MODE_SEARCH: begin
				if (hit >= 0) begin
					o.status = ST_FOUND;
					o.slot   = SLOT_W'(hit);
				end else begin
					o.status = ST_NOT_FOUND;
				end
				due_rsp.push_back(o);
			end
			default: begin
				if (tbl_count == 0) begin
					o.status = ST_EMPTY;
					due_rsp.push_back(o);
				end else begin
					n = (tbl_count < MAX_RESULTS) ? tbl_count : MAX_RESULTS;
					if (n == ENTRIES)
						n_full_lists++;
					for (i = 0; i < n; i++) begin
						o.status    = ST_LIST;
						o.slot      = SLOT_W'(i);
						o.entry_key = tbl_keys[i];
						o.last      = (i == n - 1);
						due_rsp.push_back(o);
					end
				end
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [KEY_W-1:0] want,
			logic [KEY_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_errors++;
		end
	endfunction

	// Predict on every accepted item, check every result, watch for a hang
	always @(posedge clk) begin
		rsp_t want;
		logic took;
		if (arst_n) begin
			took = start && !busy;
			if (took)
				apply_request(req);
			if (done === 1'b1) begin
				n_results++;
				if (due_rsp.size() == 0) begin
					$error("result with nothing expected: status %0d slot %0d",
						rsp.status, rsp.slot);
					n_errors++;
				end else begin
					want = due_rsp.pop_front();
					check_field("status", KEY_W'(want.status), KEY_W'(rsp.status));
					check_field("slot", KEY_W'(want.slot), KEY_W'(rsp.slot));
					check_field("entry_key", want.entry_key, rsp.entry_key);
					check_field("last", KEY_W'(want.last), KEY_W'(rsp.last));
				end
			end
			quiet = (took || done === 1'b1) ? 0 : quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_top: no item or result for %0d cycles", QUIET_LIMIT);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	// Present one item and hold it until the block takes it
	task automatic send_item(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key);
		req_t r;
		r.mode = mode;
		r.key  = key;
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
		n_items++;
	endtask

	task automatic pause(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until every predicted result has come back; first let a clock
	// edge pass so the item just taken is already in the queue
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (due_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_table();
		send_item(MODE_LIST, '1);
		send_item(MODE_SEARCH, '0);
		send_item(MODE_DELETE, '1);
	endtask

	task automatic test_create_search();
		send_item(MODE_CREATE, key_pool[0]);
		send_item(MODE_CREATE, key_pool[1]);
		send_item(MODE_CREATE, key_pool[0]);
		send_item(MODE_SEARCH, key_pool[1]);
		send_item(MODE_LIST, '0);
	endtask

	// Fill every slot, overflow it, list it whole, delete from the front
	task automatic test_fill_and_full();
		int i;
		for (i = 2; i < ENTRIES; i++)
			send_item(MODE_CREATE, key_pool[i]);
		send_item(MODE_CREATE, key_pool[ENTRIES]);
		send_item(MODE_LIST, key_pool[3]);
		send_item(MODE_DELETE, key_pool[0]);
		wait_drained();
	endtask

	// Alternate growing and shrinking bursts over a small key pool
	task automatic test_random(int idle_pct, int count);
		int               k;
		int               pick;
		logic             grow;
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
		grow = 1'b0;
		for (k = 0; k < count; k++) begin
			if (k % 25 == 0)
				grow = !grow;
			pick = $urandom_range(0, 99);
			if (pick < (grow ? 50 : 15))
				mode = MODE_CREATE;
			else if (pick < 65)
				mode = MODE_DELETE;
			else if (pick < 85)
				mode = MODE_SEARCH;
			else
				mode = MODE_LIST;
			if ($urandom_range(0, 99) < 85)
				key = key_pool[$urandom_range(0, POOL_N - 1)];
			else
				key = {$urandom, $urandom};
			send_item(mode, key);
			if (k == count / 2)
				wait_drained();
			else if ($urandom_range(0, 99) < idle_pct)
				pause($urandom_range(1, 4));
		end
		wait_drained();
	endtask

	initial begin
		int i;
		tbl_count    = 0;
		n_items      = 0;
		n_results    = 0;
		n_errors     = 0;
		n_full_hits  = 0;
		n_full_lists = 0;
		quiet        = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (i = 2; i < POOL_N; i++)
			key_pool[i] = {$urandom, $urandom};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_create_search();
		test_fill_and_full();
		test_random(0, 100);
		test_random(58, 100);
		test_random(8, 100);

		// Let any stray result show up before closing
		wait_drained();
		repeat (24) @(posedge clk);
		if (due_rsp.size() != 0) begin
			$error("%0d expected results never arrived", due_rsp.size());
			n_errors++;
		end
		$display("tb_top: %0d items sent, %0d results checked, %0d mismatches",
			n_items, n_results, n_errors);
		$display("tb_top: create on full table %0d times, full-table list %0d times",
			n_full_hits, n_full_lists);
		if (n_errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
